// ===== rtl/ssls_pkg.sv =====
// Shared types and constants for the segmented-sum limited stack unit.
// No dependencies; used by every module of the block.
`default_nettype none

package ssls_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int VALUE_W     = 16;
	localparam int TOTAL_W     = 11;

	localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'd1000;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [VALUE_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] popped_value;
		logic               was_empty;
		logic               was_full;
		logic [TOTAL_W-1:0] segment_total;
		logic [VALUE_W-1:0] top_sum;
		logic [TOTAL_W-1:0] item_total;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/segmented_sum_limited_stack_unit.sv =====
// Top level of the segmented-sum limited stack unit.
// Depends on ssls_pkg, ssls_ctrl and ssls_datapath.
//
// A last-in first-out store of 16-bit values split into segments; a push that
// would take the top sum past segment_limit opens one. Requests arrive on
// req_valid/req_ready with a push or pop in req; each request gives exactly
// one result on res_valid/res_ready carrying the popped value, the empty and
// full flags, the segment and item counts and the top segment's sum.
// segment_limit is written on cfg_valid/cfg_ready with cfg_data; cfg_ready
// is always high and writes are expected only while the unit is idle.
// A request and the synchronous read of its top value and segment sum are
// registered on acceptance; its result is written back into the output register
// once that is free, and a new request is accepted only after that write-back.
// Reset clears the counters and top sum and sets the limit to 1000; the
// memories are not cleared and need no clearing pass.
// If the receiver stalls, the result waits in the output register; one more
// request is accepted and held until that register frees.
`default_nettype none

module segmented_sum_limited_stack_unit #(
	parameter int STORE_DEPTH = ssls_pkg::STORE_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [ssls_pkg::VALUE_W-1:0] cfg_data,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  ssls_pkg::req_t               req,
	output logic                         res_valid,
	input  wire                          res_ready,
	output ssls_pkg::res_t               res
);

	ssls_pkg::cmd_t cmd;
	logic           cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	ssls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (cmd)
	);

	ssls_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== rtl/ssls_ctrl.sv =====
// Controller of the segmented-sum limited stack unit: request sequencing and
// the valid flag of the result register. Depends on ssls_pkg.
`default_nettype none

module ssls_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	output logic             res_valid,
	input  wire              res_ready,
	output ssls_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free    = !res_valid_q || res_ready;
	assign req_ready   = (state_q == ST_IDLE);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == ST_EXEC) && out_free;
	assign res_valid   = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// A request is only taken while no other is in flight.
	a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !cmd.capture)
		else $error("request captured while another is executing");

	// Every captured request goes on to execution, where it commits a result before the next capture.
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("captured request did not reach execution");

	// A waiting result is never overwritten by a new commit.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !cmd.commit)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/ssls_datapath.sv =====
// Datapath of the segmented-sum limited stack unit: value and segment-sum
// memories, counters, limit register and result register. Depends on ssls_pkg.
`default_nettype none

module ssls_datapath #(
	parameter int STORE_DEPTH = ssls_pkg::STORE_DEPTH
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_write,
	input  wire  [ssls_pkg::VALUE_W-1:0]       cfg_data,
	input  ssls_pkg::req_t                     req,
	input  ssls_pkg::cmd_t                     cmd,
	output ssls_pkg::res_t                     res
);

	localparam int VW = ssls_pkg::VALUE_W;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);

	// Each value entry carries its segment-start mark in the top bit.
	logic [VW:0]   val_mem [STORE_DEPTH];
	logic [VW-1:0] sum_mem [STORE_DEPTH];

	logic [CW-1:0] item_cnt_q;
	logic [CW-1:0] seg_cnt_q;
	logic [VW-1:0] top_sum_q;
	logic [VW-1:0] limit_q;

	ssls_pkg::req_t req_s1;
	logic [VW:0]    rd_entry_s1;
	logic [VW-1:0]  rd_sum_s1;
	ssls_pkg::res_t res_q;

	logic [CW-1:0] item_m1;
	logic [CW-1:0] seg_m1;
	logic [CW-1:0] seg_m2;
	logic [AW-1:0] rd_slot;
	logic [AW-1:0] rd_seg;
	logic [AW-1:0] wr_slot;
	logic [AW-1:0] wr_seg;

	logic          is_push;
	logic          full;
	logic          empty;
	logic          seg_zero;
	logic [VW:0]   sum_ext;
	logic          opens;
	logic          closes;
	logic          val_we;
	logic          sum_we;
	logic [CW-1:0] item_d;
	logic [CW-1:0] seg_d;
	logic [VW-1:0] top_d;
	logic [VW-1:0] popped;
	ssls_pkg::res_t res_d;

	assign item_m1 = item_cnt_q - CW'(1);
	assign seg_m1  = seg_cnt_q - CW'(1);
	assign seg_m2  = seg_cnt_q - CW'(2);
	assign rd_slot = item_m1[AW-1:0];
	assign rd_seg  = seg_m2[AW-1:0];
	assign wr_slot = item_cnt_q[AW-1:0];
	assign wr_seg  = seg_m1[AW-1:0];

	assign is_push  = (req_s1.req_type == ssls_pkg::REQ_PUSH);
	assign full     = (item_cnt_q == CW'(STORE_DEPTH));
	assign empty    = (item_cnt_q == '0);
	assign seg_zero = (seg_cnt_q == '0);
	assign sum_ext  = {1'b0, top_sum_q} + {1'b0, req_s1.push_value};
	assign opens    = seg_zero || (sum_ext > {1'b0, limit_q});
	assign popped   = rd_entry_s1[VW-1:0];
	// The last value leaving also closes a lone segment that lacks a mark.
	assign closes   = rd_entry_s1[VW] || ((seg_cnt_q <= CW'(1)) && (item_m1 == '0));

	assign val_we = cmd.commit && is_push && !full;
	assign sum_we = val_we && opens && !seg_zero;

	always_comb begin
		item_d = item_cnt_q;
		seg_d  = seg_cnt_q;
		top_d  = top_sum_q;
		res_d  = '0;
		if (is_push) begin
			if (full) begin
				res_d.was_full = 1'b1;
			end else begin
				item_d = item_cnt_q + CW'(1);
				if (opens) begin
					seg_d = seg_cnt_q + CW'(1);
					top_d = req_s1.push_value;
				end else begin
					top_d = sum_ext[VW-1:0];
				end
			end
		end else begin
			if (empty) begin
				res_d.was_empty = 1'b1;
			end else begin
				res_d.popped_value = popped;
				item_d             = item_m1;
				if (closes) begin
					if (!seg_zero) begin
						seg_d = seg_m1;
					end
					if (seg_cnt_q > CW'(1)) begin
						top_d = rd_sum_s1;
					end else begin
						top_d = '0;
					end
				end else begin
					top_d = top_sum_q - popped;
				end
			end
		end
		res_d.segment_total = ssls_pkg::TOTAL_W'(seg_d);
		res_d.top_sum       = top_d;
		res_d.item_total    = ssls_pkg::TOTAL_W'(item_d);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1      <= req;
			rd_entry_s1 <= val_mem[rd_slot];
			rd_sum_s1   <= sum_mem[rd_seg];
		end
		if (val_we) begin
			val_mem[wr_slot] <= {opens, req_s1.push_value};
		end
		if (sum_we) begin
			sum_mem[wr_seg] <= top_sum_q;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q <= '0;
			seg_cnt_q  <= '0;
			top_sum_q  <= '0;
			limit_q    <= ssls_pkg::LIMIT_RESET;
		end else begin
			if (cfg_write) begin
				limit_q <= cfg_data;
			end
			if (cmd.commit) begin
				item_cnt_q <= item_d;
				seg_cnt_q  <= seg_d;
				top_sum_q  <= top_d;
			end
		end
	end

	assign res = res_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= CW'(STORE_DEPTH))
		else $error("item count exceeds store depth");

	// Every segment holds at least one value, and values always sit in a segment.
	a_seg_vs_items: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_cnt_q <= item_cnt_q) && ((seg_cnt_q == '0) == (item_cnt_q == '0)))
		else $error("segment count inconsistent with item count");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(item_cnt_q == '0) |-> (top_sum_q == '0))
		else $error("empty store with non-zero top sum");

	// A dropped push leaves the counters untouched.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_push && full) |=> $stable(item_cnt_q) && $stable(seg_cnt_q))
		else $error("dropped push changed the counters");

endmodule

`default_nettype wire

// ===== verif/segmented_sum_stack_checker.sv =====
// Checker for the segmented-sum limited stack unit: predicts each result and compares it.
// Depends on ssls_pkg; instantiated beside the block by segmented_sum_limited_stack_unit_tb.
module segmented_sum_stack_checker
	import ssls_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	input  wire                cfg_ready,
	input  wire  [VALUE_W-1:0] cfg_data,
	input  wire                req_valid,
	input  wire                req_ready,
	input  req_t               req,
	input  wire                res_valid,
	input  wire                res_ready,
	input  res_t               res,
	output int                 error_count,
	output int                 pending,
	output int                 full_drops,
	output int                 empty_pops
);
	timeunit 1ns;
	timeprecision 1ps;

	// The checker's own copy of the stack.
	logic [VALUE_W-1:0] stored_vals [STORE_DEPTH];
	logic               opens_segment [STORE_DEPTH];
	logic [VALUE_W-1:0] closed_sums [STORE_DEPTH];
	int                 n_items;
	int                 n_segments;
	logic [VALUE_W-1:0] top_total;
	logic [VALUE_W-1:0] seg_limit;

	res_t expected_results [$];
	int   queued = 0;
	int   errors_seen = 0;
	int   results_seen = 0;
	int   full_seen = 0;
	int   empty_seen = 0;

	assign error_count = errors_seen;
	assign pending     = queued;
	assign full_drops  = full_seen;
	assign empty_pops  = empty_seen;

	task automatic report_mismatch(input string msg);
		// Printing stops after a hundred lines so a broken block cannot flood the log.
		if (errors_seen < 100) begin
			$display("%0t ns: MISMATCH: %s", $realtime, msg);
		end
		errors_seen++;
	endtask

	task automatic compare_field(input string field, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s is %0d, expected %0d", results_seen,
				field, got, want));
		end
	endtask

	function automatic res_t apply_request(input req_t r);
		res_t       outcome;
		logic [VALUE_W:0] grown;
		outcome = '0;
		if (r.req_type == REQ_PUSH) begin
			if (n_items >= STORE_DEPTH) begin
				outcome.was_full = 1'b1;
				full_seen++;
			end else begin
				// The sum is taken one bit wider so that a wrap past 65535 still opens.
				grown = {1'b0, top_total} + {1'b0, r.push_value};
				if (n_segments == 0 || grown > {1'b0, seg_limit}) begin
					if (n_segments != 0) begin
						closed_sums[n_segments - 1] = top_total;
					end
					n_segments++;
					top_total = r.push_value;
					opens_segment[n_items] = 1'b1;
				end else begin
					top_total = grown[VALUE_W-1:0];
					opens_segment[n_items] = 1'b0;
				end
				stored_vals[n_items] = r.push_value;
				n_items++;
			end
		end else if (n_items == 0) begin
			outcome.was_empty = 1'b1;
			empty_seen++;
		end else begin
			n_items--;
			outcome.popped_value = stored_vals[n_items];
			if (opens_segment[n_items] || (n_segments <= 1 && n_items == 0)) begin
				if (n_segments > 0) begin
					n_segments--;
				end
				top_total = (n_segments > 0) ? closed_sums[n_segments - 1] : '0;
			end else begin
				top_total = top_total - outcome.popped_value;
			end
		end
		outcome.segment_total = TOTAL_W'(n_segments);
		outcome.top_sum       = top_total;
		outcome.item_total    = TOTAL_W'(n_items);
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			n_items    = 0;
			n_segments = 0;
			top_total  = '0;
			seg_limit  = LIMIT_RESET;
			expected_results.delete();
			queued <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seg_limit = cfg_data;
			end
			// A result always belongs to an earlier request, so it is checked first.
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with no request waiting: %p", res));
				end else begin
					want = expected_results.pop_front();
					compare_field("popped_value", res.popped_value, want.popped_value);
					compare_field("was_empty", 16'(res.was_empty), 16'(want.was_empty));
					compare_field("was_full", 16'(res.was_full), 16'(want.was_full));
					compare_field("segment_total", 16'(res.segment_total),
						16'(want.segment_total));
					compare_field("top_sum", res.top_sum, want.top_sum);
					compare_field("item_total", 16'(res.item_total), 16'(want.item_total));
				end
				results_seen++;
			end
			if (req_valid && req_ready) begin
				expected_results.push_back(apply_request(req));
			end
			queued <= expected_results.size();
		end
	end

endmodule

// ===== verif/segmented_sum_limited_stack_unit_tb.sv =====
// Top of the testbench for the segmented-sum limited stack unit: clock, reset and stimulus.
// Depends on ssls_pkg, segmented_sum_limited_stack_unit and segmented_sum_stack_checker.
module segmented_sum_limited_stack_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssls_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [VALUE_W-1:0] cfg_data = '0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	res_t               res;

	int error_count;
	int pending;
	int full_drops;
	int empty_pops;

	int                 cycle_count = 0;
	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	logic [VALUE_W-1:0] cur_limit = LIMIT_RESET;
	int                 push_count = 0;
	int                 pop_count = 0;
	int                 limit_writes = 0;

	segmented_sum_limited_stack_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	segmented_sum_stack_checker stack_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.error_count (error_count),
		.pending     (pending),
		.full_drops  (full_drops),
		.empty_pops  (empty_pops)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
				pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [VALUE_W-1:0] value);
		req_t item;
		item.req_type   = op;
		item.push_value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (op == REQ_PUSH) begin
			push_count++;
		end else begin
			pop_count++;
		end
	endtask

	// The outstanding count is registered after acceptance, hence the first wait.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [VALUE_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_limit = value;
		limit_writes++;
	endtask

	task automatic set_idling(input int idle_pct, input int stall);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
	endtask

	// Values are mostly small against the limit so that segments fill over several pushes.
	function automatic logic [VALUE_W-1:0] pick_value();
		int pick;
		int span;
		int near;
		pick = $urandom_range(9);
		span = cur_limit / 3 + 1;
		near = int'(cur_limit) - 2 + int'($urandom_range(4));
		case (pick)
			0: return '0;
			1: return '1;
			2, 3: return VALUE_W'($urandom_range(65535));
			9: return VALUE_W'((near < 0) ? 0 : (near > 65535) ? 65535 : near);
			default: return VALUE_W'($urandom_range(span));
		endcase
	endfunction

	task automatic random_burst(input int count, input int push_pct);
		for (int i = 0; i < count; i++) begin
			send_request(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP, pick_value());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests against the reset limit of 1000.
		send_request(REQ_POP, 16'hFFFF);
		send_request(REQ_PUSH, 16'hFFFF);
		send_request(REQ_POP, 16'h0000);
		send_request(REQ_PUSH, 16'd0);
		send_request(REQ_PUSH, 16'd1000);
		send_request(REQ_PUSH, 16'd1);
		send_request(REQ_PUSH, 16'hFFFF);
		send_request(REQ_PUSH, 16'd0);
		send_request(REQ_PUSH, 16'd400);
		send_request(REQ_PUSH, 16'd600);
		send_request(REQ_PUSH, 16'd1);
		repeat (8) send_request(REQ_POP, 16'h5555);
		send_request(REQ_POP, 16'hAAAA);

		random_burst(200, 55);

		write_limit('0);
		set_idling(73, 0);
		random_burst(150, 50);

		write_limit('1);
		set_idling(0, 73);
		random_burst(200, 60);

		write_limit(VALUE_W'($urandom_range(1, 3000)));
		set_idling(14, 14);
		random_burst(150, 50);

		// Push only, long enough to reach a full store from any depth.
		write_limit(VALUE_W'($urandom_range(100, 20000)));
		set_idling(0, 0);
		random_burst(1040, 100);

		write_limit(16'd1000);
		set_idling(0, 73);
		random_burst(300, 30);

		wait_drained();
		repeat (10) @(posedge clk);

		$display("Ran %0d requests (%0d pushes, %0d pops) through %0d limit settings,",
			push_count + pop_count, push_count, pop_count, limit_writes + 1);
		$display("with %0d pushes dropped on a full store and %0d pops on an empty one.",
			full_drops, empty_pops);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
